// ===== rtl/core/dmi_pkg.sv =====
// Shared types and constants for the directional movement index block.
package dmi_pkg;

	localparam int DATA_W   = 64;
	localparam int IN_W     = 32;
	localparam int PERIOD_W = 8;
	localparam int OUT_W    = 23;
	localparam int CNT_W    = 10;

	localparam logic [CNT_W-1:0]    BARS_MAX     = 10'd511;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_CALC  = 12'b0000_0000_0010,
		ST_WARM  = 12'b0000_0000_0100,
		ST_DIV_R = 12'b0000_0000_1000,
		ST_DIV_U = 12'b0000_0001_0000,
		ST_DIV_D = 12'b0000_0010_0000,
		ST_PCT_P = 12'b0000_0100_0000,
		ST_PCT_M = 12'b0000_1000_0000,
		ST_PCT_X = 12'b0001_0000_0000,
		ST_ADX   = 12'b0010_0000_0000,
		ST_DIV_A = 12'b0100_0000_0000,
		ST_DONE  = 12'b1000_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		DSEL_RANGE,
		DSEL_UP,
		DSEL_DOWN,
		DSEL_ADX
	} div_sel_t;

	typedef enum logic [1:0] {
		PSEL_PLUS,
		PSEL_MINUS,
		PSEL_DX
	} pct_sel_t;

	typedef struct packed {
		logic     load;
		logic     calc;
		logic     warm_add;
		logic     div_start;
		logic     div_wb;
		div_sel_t div_sel;
		logic     pct_start;
		logic     pct_wb;
		pct_sel_t pct_sel;
		logic     adx_step;
		logic     finish;
	} ctrl_t;

	typedef struct packed {
		logic first_bar;
		logic warmup;
		logic dx_early;
		logic div_done;
		logic pct_done;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/core/dmi_div.sv =====
// Restoring serial divider: 64-bit dividend by the 8-bit period, one bit per cycle.
module dmi_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dmi_pkg::DATA_W-1:0]    dividend,
	input  logic [dmi_pkg::PERIOD_W-1:0]  divisor,
	output logic                          done,
	output logic [dmi_pkg::DATA_W-1:0]    quotient
);

	localparam int CW = $clog2(dmi_pkg::DATA_W);

	logic                           busy_q;
	logic                           done_q;
	logic [CW-1:0]                  cnt_q;
	logic [dmi_pkg::DATA_W-1:0]     num_q;
	logic [dmi_pkg::PERIOD_W-1:0]   rem_q;
	logic [dmi_pkg::PERIOD_W:0]     trial;
	logic [dmi_pkg::PERIOD_W:0]     rem_n;
	logic                           ge;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial = {rem_q, num_q[dmi_pkg::DATA_W-1]};
		ge    = trial >= {1'b0, divisor};
		rem_n = ge ? (trial - {1'b0, divisor}) : trial;
	end

	// Control: run for one step per dividend bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(dmi_pkg::DATA_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Shift quotient bits in as dividend bits leave
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[dmi_pkg::DATA_W-2:0], ge};
			rem_q <= rem_n[dmi_pkg::PERIOD_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

// ===== rtl/core/dmi_pct.sv =====
// Serial percent ratio unit: floor(x * 100% / d) by shift-and-add modulo d.
module dmi_pct #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dmi_pkg::DATA_W-1:0]    x,
	input  logic [dmi_pkg::DATA_W-1:0]    d,
	output logic                          done,
	output logic [FRACTION_BITS+6:0]      quot
);

	localparam int PCT_W = FRACTION_BITS + 7;
	localparam int BIT_W = $clog2(PCT_W);
	localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100) << FRACTION_BITS;

	logic                         busy_q;
	logic                         phase_q;
	logic                         done_q;
	logic [BIT_W-1:0]             bit_q;
	logic [dmi_pkg::DATA_W-1:0]   r_q;
	logic [PCT_W:0]               q_q;
	logic [PCT_W-1:0]             quot_q;
	logic [dmi_pkg::DATA_W-1:0]   addend;
	logic [dmi_pkg::DATA_W:0]     sum;
	logic [dmi_pkg::DATA_W+1:0]   diff;
	logic                         carry;
	logic [dmi_pkg::DATA_W-1:0]   r_n;
	logic [PCT_W:0]               q_add;
	logic                         early;

	// Add modulo d: doubling in the first phase, add x in the second
	always_comb begin
		addend = phase_q ? x : r_q;
		sum    = {1'b0, r_q} + {1'b0, addend};
		diff   = {1'b0, sum} - {2'b0, d};
		carry  = !diff[dmi_pkg::DATA_W+1];
		r_n    = carry ? diff[dmi_pkg::DATA_W-1:0] : sum[dmi_pkg::DATA_W-1:0];
		q_add  = q_q + {{PCT_W{1'b0}}, carry};
		early  = (d == '0) || (x >= d);
	end

	// Control: two phases per bit of the percent constant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			bit_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				if (early) begin
					done_q <= 1'b1;
				end else begin
					busy_q  <= 1'b1;
					phase_q <= 1'b0;
					bit_q   <= BIT_W'(PCT_W - 1);
				end
			end else if (busy_q) begin
				if (!phase_q) begin
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					if (bit_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
			end
		end
	end

	// Remainder and quotient steps
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			r_q <= '0;
			q_q <= '0;
			if (d == '0) begin
				quot_q <= '0;
			end else if (x >= d) begin
				quot_q <= PCT_FULL;
			end
		end else if (busy_q) begin
			if (!phase_q) begin
				r_q <= r_n;
				q_q <= {q_q[PCT_W-1:0], carry};
			end else if (PCT_FULL[bit_q]) begin
				r_q <= r_n;
				q_q <= q_add;
				if (bit_q == '0) begin
					quot_q <= (q_add > {1'b0, PCT_FULL}) ? PCT_FULL : q_add[PCT_W-1:0];
				end
			end else if (bit_q == '0) begin
				quot_q <= (q_q > {1'b0, PCT_FULL}) ? PCT_FULL : q_q[PCT_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== rtl/core/dmi_ctrl.sv =====
// Controller state machine sequencing the per-bar work of the datapath.
module dmi_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dmi_pkg::stat_t  stat,
	output dmi_pkg::ctrl_t  ctl
);

	dmi_pkg::state_t state_q;
	dmi_pkg::state_t state_n;
	logic            run_q;
	logic            run_n;

	// Next state and commands
	always_comb begin
		state_n     = state_q;
		run_n       = run_q;
		ctl         = '0;
		ctl.div_sel = dmi_pkg::DSEL_RANGE;
		ctl.pct_sel = dmi_pkg::PSEL_PLUS;
		case (state_q)
			dmi_pkg::ST_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_n  = dmi_pkg::ST_CALC;
				end
			end
			dmi_pkg::ST_CALC: begin
				ctl.calc = 1'b1;
				if (stat.first_bar) begin
					state_n = dmi_pkg::ST_DONE;
				end else if (stat.warmup) begin
					state_n = dmi_pkg::ST_WARM;
				end else begin
					state_n = dmi_pkg::ST_DIV_R;
				end
			end
			dmi_pkg::ST_WARM: begin
				ctl.warm_add = 1'b1;
				state_n      = dmi_pkg::ST_DONE;
			end
			dmi_pkg::ST_DIV_R, dmi_pkg::ST_DIV_U, dmi_pkg::ST_DIV_D, dmi_pkg::ST_DIV_A: begin
				case (state_q)
					dmi_pkg::ST_DIV_R: ctl.div_sel = dmi_pkg::DSEL_RANGE;
					dmi_pkg::ST_DIV_U: ctl.div_sel = dmi_pkg::DSEL_UP;
					dmi_pkg::ST_DIV_D: ctl.div_sel = dmi_pkg::DSEL_DOWN;
					default:           ctl.div_sel = dmi_pkg::DSEL_ADX;
				endcase
				if (!run_q) begin
					ctl.div_start = 1'b1;
					run_n         = 1'b1;
				end else if (stat.div_done) begin
					ctl.div_wb = 1'b1;
					run_n      = 1'b0;
					case (state_q)
						dmi_pkg::ST_DIV_R: state_n = dmi_pkg::ST_DIV_U;
						dmi_pkg::ST_DIV_U: state_n = dmi_pkg::ST_DIV_D;
						dmi_pkg::ST_DIV_D: state_n = dmi_pkg::ST_PCT_P;
						default:           state_n = dmi_pkg::ST_DONE;
					endcase
				end
			end
			dmi_pkg::ST_PCT_P, dmi_pkg::ST_PCT_M, dmi_pkg::ST_PCT_X: begin
				case (state_q)
					dmi_pkg::ST_PCT_P: ctl.pct_sel = dmi_pkg::PSEL_PLUS;
					dmi_pkg::ST_PCT_M: ctl.pct_sel = dmi_pkg::PSEL_MINUS;
					default:           ctl.pct_sel = dmi_pkg::PSEL_DX;
				endcase
				if (!run_q) begin
					ctl.pct_start = 1'b1;
					run_n         = 1'b1;
				end else if (stat.pct_done) begin
					ctl.pct_wb = 1'b1;
					run_n      = 1'b0;
					case (state_q)
						dmi_pkg::ST_PCT_P: state_n = dmi_pkg::ST_PCT_M;
						dmi_pkg::ST_PCT_M: state_n = dmi_pkg::ST_PCT_X;
						default:           state_n = dmi_pkg::ST_ADX;
					endcase
				end
			end
			dmi_pkg::ST_ADX: begin
				ctl.adx_step = 1'b1;
				state_n      = stat.dx_early ? dmi_pkg::ST_DONE : dmi_pkg::ST_DIV_A;
			end
			dmi_pkg::ST_DONE: begin
				if (stat.out_free) begin
					ctl.finish = 1'b1;
					state_n    = dmi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = dmi_pkg::ST_IDLE;
				run_n   = 1'b0;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmi_pkg::ST_IDLE;
			run_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			run_q   <= run_n;
		end
	end

	assign in_ready = (state_q == dmi_pkg::ST_IDLE);

	a_load_to_calc: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> state_q == dmi_pkg::ST_CALC)
		else $error("accepted bar did not move to move calculation");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == dmi_pkg::ST_DIV_R || state_q == dmi_pkg::ST_DIV_U ||
			state_q == dmi_pkg::ST_DIV_D || state_q == dmi_pkg::ST_DIV_A))
		else $error("divider finished outside a divide step");

	a_pct_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pct_done |-> (state_q == dmi_pkg::ST_PCT_P || state_q == dmi_pkg::ST_PCT_M ||
			state_q == dmi_pkg::ST_PCT_X))
		else $error("ratio unit finished outside a ratio step");

endmodule

// ===== rtl/core/dmi_dp.sv =====
// Datapath: bar registers, smoothed sums, DI and ADX state, shared units, result register.
module dmi_dp #(
	parameter int PRICE_BITS    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dmi_pkg::ctrl_t                ctl,
	output dmi_pkg::stat_t                stat,
	input  logic [dmi_pkg::PERIOD_W-1:0]  period,
	input  logic [dmi_pkg::IN_W-1:0]      bar_high,
	input  logic [dmi_pkg::IN_W-1:0]      bar_low,
	input  logic [dmi_pkg::IN_W-1:0]      bar_close,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dmi_pkg::OUT_W-1:0]     plus_di,
	output logic [dmi_pkg::OUT_W-1:0]     minus_di,
	output logic [dmi_pkg::OUT_W-1:0]     adx_value,
	output logic                          di_ready,
	output logic                          adx_ready
);

	localparam int DW    = dmi_pkg::DATA_W;
	localparam int IW    = dmi_pkg::IN_W;
	localparam int CW    = dmi_pkg::CNT_W;
	localparam int PW    = dmi_pkg::PERIOD_W;
	localparam int PCT_W = FRACTION_BITS + 7;
	localparam logic [IW-1:0] PMASK =
		(PRICE_BITS >= IW) ? {IW{1'b1}} : IW'((64'd1 << PRICE_BITS) - 64'd1);

	logic [IW-1:0]    h_q, l_q, c_q;
	logic [IW-1:0]    ph_q, pl_q, pc_q;
	logic [CW-1:0]    bars_q;
	logic [DW-1:0]    sr_q, su_q, sd_q, acc_q, num_q;
	logic [PCT_W-1:0] pdi_q, mdi_q, dx_q;
	logic [IW-1:0]    tr_q, up_q, dn_q;
	logic             out_valid_q;
	logic [dmi_pkg::OUT_W-1:0] pdi_o_q, mdi_o_q, adx_o_q;
	logic             di_o_q, adx_o_q_rdy;

	logic [PW-1:0]    p_eff;
	logic [PW-1:0]    p_m1;
	logic [CW-1:0]    p_cnt, p2;
	logic             smoothed, di_ok, adx_ok, first_avg;
	logic signed [IW+1:0] hd, ld, hl, hc, lc, tr_s;
	logic [IW-1:0]    tr_c, up_c, dn_c;
	logic [31+PW:0]   acc_mul;

	logic [DW-1:0]    div_num, div_q;
	logic             div_done;
	logic [DW-1:0]    pct_x, pct_d;
	logic [PCT_W-1:0] pct_q, dx_abs;
	logic [PCT_W:0]   di_sum;
	logic             pct_done;

	// Effective period and readiness thresholds
	always_comb begin
		p_eff     = (period == '0) ? PW'(1) : period;
		p_m1      = p_eff - 1'b1;
		p_cnt     = {{(CW-PW){1'b0}}, p_eff};
		p2        = p_cnt << 1;
		smoothed  = (bars_q != '0) && (bars_q > p_cnt);
		di_ok     = smoothed && ((bars_q + 1'b1) >= p2);
		adx_ok    = smoothed && (bars_q >= p2);
		first_avg = (bars_q == p2);
	end

	// True range and directional moves against the prior bar
	always_comb begin
		hd = $signed({2'b0, h_q}) - $signed({2'b0, ph_q});
		ld = $signed({2'b0, pl_q}) - $signed({2'b0, l_q});
		hl = $signed({2'b0, h_q}) - $signed({2'b0, l_q});
		hc = $signed({2'b0, h_q}) - $signed({2'b0, pc_q});
		lc = $signed({2'b0, l_q}) - $signed({2'b0, pc_q});
		if (hc < 0) hc = -hc;
		if (lc < 0) lc = -lc;
		tr_s = hl;
		if (tr_s < hc) tr_s = hc;
		if (tr_s < lc) tr_s = lc;
		tr_c = tr_s[IW-1:0];
		up_c = (hd > ld && hd > 0) ? hd[IW-1:0] : '0;
		dn_c = (ld > hd && ld > 0) ? ld[IW-1:0] : '0;
	end

	// Scale the running ADX by period minus one; the accumulator stays below 2^32
	always_comb begin
		acc_mul = {{PW{1'b0}}, acc_q[31:0]} * {32'd0, p_m1};
	end

	function automatic logic [DW-1:0] scale_in(input logic [IW-1:0] v);
		logic [DW-1:0] e;
		e = {{(DW-IW){1'b0}}, v};
		return e << FRACTION_BITS;
	endfunction

	// Operand selection for the shared units
	always_comb begin
		case (ctl.div_sel)
			dmi_pkg::DSEL_RANGE: div_num = sr_q;
			dmi_pkg::DSEL_UP:    div_num = su_q;
			dmi_pkg::DSEL_DOWN:  div_num = sd_q;
			default:             div_num = num_q;
		endcase
		dx_abs = (pdi_q > mdi_q) ? (pdi_q - mdi_q) : (mdi_q - pdi_q);
		di_sum = {1'b0, pdi_q} + {1'b0, mdi_q};
		case (ctl.pct_sel)
			dmi_pkg::PSEL_PLUS: begin
				pct_x = su_q;
				pct_d = sr_q;
			end
			dmi_pkg::PSEL_MINUS: begin
				pct_x = sd_q;
				pct_d = sr_q;
			end
			default: begin
				pct_x = {{(DW-PCT_W){1'b0}}, dx_abs};
				pct_d = {{(DW-PCT_W-1){1'b0}}, di_sum};
			end
		endcase
	end

	dmi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (div_num),
		.divisor  (p_eff),
		.done     (div_done),
		.quotient (div_q)
	);

	dmi_pct #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_pct (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.pct_start),
		.x      (pct_x),
		.d      (pct_d),
		.done   (pct_done),
		.quot   (pct_q)
	);

	// Capture the bar and its moves, the DX and the next ADX numerator
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			h_q <= bar_high & PMASK;
			l_q <= bar_low & PMASK;
			c_q <= bar_close & PMASK;
		end
		if (ctl.calc) begin
			tr_q <= tr_c;
			up_q <= up_c;
			dn_q <= dn_c;
		end
		if (ctl.pct_wb && ctl.pct_sel == dmi_pkg::PSEL_DX) begin
			dx_q <= pct_q;
		end
		if (ctl.adx_step) begin
			num_q <= first_avg ? (acc_q + {{(DW-PCT_W){1'b0}}, dx_q})
				: ({{(DW-32-PW){1'b0}}, acc_mul} + {{(DW-PCT_W){1'b0}}, dx_q});
		end
	end

	// Series state: priors, count, sums, DI and ADX
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= '0;
			pl_q   <= '0;
			pc_q   <= '0;
			bars_q <= '0;
			sr_q   <= '0;
			su_q   <= '0;
			sd_q   <= '0;
			acc_q  <= '0;
			pdi_q  <= '0;
			mdi_q  <= '0;
		end else begin
			if (ctl.warm_add) begin
				sr_q <= sr_q + scale_in(tr_q);
				su_q <= su_q + scale_in(up_q);
				sd_q <= sd_q + scale_in(dn_q);
			end
			if (ctl.div_wb) begin
				case (ctl.div_sel)
					dmi_pkg::DSEL_RANGE: sr_q  <= sr_q - div_q + scale_in(tr_q);
					dmi_pkg::DSEL_UP:    su_q  <= su_q - div_q + scale_in(up_q);
					dmi_pkg::DSEL_DOWN:  sd_q  <= sd_q - div_q + scale_in(dn_q);
					default:             acc_q <= div_q;
				endcase
			end
			if (ctl.pct_wb) begin
				case (ctl.pct_sel)
					dmi_pkg::PSEL_PLUS:  pdi_q <= pct_q;
					dmi_pkg::PSEL_MINUS: mdi_q <= pct_q;
					default: ;
				endcase
			end
			if (ctl.adx_step && stat.dx_early) begin
				acc_q <= acc_q + {{(DW-PCT_W){1'b0}}, dx_q};
			end
			if (ctl.finish) begin
				ph_q   <= h_q;
				pl_q   <= l_q;
				pc_q   <= c_q;
				bars_q <= (bars_q >= dmi_pkg::BARS_MAX) ? dmi_pkg::BARS_MAX : bars_q + 1'b1;
			end
		end
	end

	// Result register: load on finish, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			pdi_o_q     <= di_ok ? dmi_pkg::OUT_W'(pdi_q) : '0;
			mdi_o_q     <= di_ok ? dmi_pkg::OUT_W'(mdi_q) : '0;
			adx_o_q     <= adx_ok ? acc_q[dmi_pkg::OUT_W-1:0] : '0;
			di_o_q      <= di_ok;
			adx_o_q_rdy <= adx_ok;
		end
	end

	always_comb begin
		stat.first_bar = (bars_q == '0);
		stat.warmup    = (bars_q <= p_cnt);
		stat.dx_early  = (bars_q < p2);
		stat.div_done  = div_done;
		stat.pct_done  = pct_done;
		stat.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign plus_di   = pdi_o_q;
	assign minus_di  = mdi_o_q;
	assign adx_value = adx_o_q;
	assign di_ready  = di_o_q;
	assign adx_ready = adx_o_q_rdy;

	a_adx_needs_di: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && adx_o_q_rdy) |-> di_o_q)
		else $error("ADX flagged ready on a bar without DI ready");

endmodule

// ===== rtl/core/directional_movement_index.sv =====
// Wilder directional movement index (plus DI, minus DI, ADX) over a stream of price bars.
// One bar in, one result out. The work of each bar is done by the shared bit-serial
// divide-by-period unit (up to four times per bar) and the bit-serial percent ratio unit
// (three times per bar once the warm-up bars are past; neither unit runs during warm-up).
// The ADX divide is skipped while the first period DX values are summed, and a ratio is
// settled at once by a zero divisor or a full-scale quotient. A finished result waits in
// an output register, and the next bar is taken while it waits. The user must write the
// period register through the cfg channel only while the block is idle; the block itself
// does not enforce it. Zero acts as one.
module directional_movement_index #(
	parameter int PRICE_BITS    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,   // bar_high[31:0], bar_low[63:32], bar_close[95:64]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // plus_di[22:0], minus_di[45:23], adx_value[68:46], zero
	output logic [1:0]  m_axis_tuser,   // di_ready[0], adx_ready[1]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data        // period
);

	dmi_pkg::ctrl_t ctl;
	dmi_pkg::stat_t stat;
	logic [dmi_pkg::PERIOD_W-1:0] period_q;
	logic [dmi_pkg::OUT_W-1:0]    plus_di, minus_di, adx_value;
	logic                         di_ready, adx_ready;

	// Period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= dmi_pkg::PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			period_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	dmi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	dmi_dp #(
		.PRICE_BITS    (PRICE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.period    (period_q),
		.bar_high  (s_axis_tdata[31:0]),
		.bar_low   (s_axis_tdata[63:32]),
		.bar_close (s_axis_tdata[95:64]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.plus_di   (plus_di),
		.minus_di  (minus_di),
		.adx_value (adx_value),
		.di_ready  (di_ready),
		.adx_ready (adx_ready)
	);

	assign m_axis_tdata = {3'b000, adx_value, minus_di, plus_di};
	assign m_axis_tuser = {adx_ready, di_ready};

endmodule
